### rtl/core/dqab_pkg.sv
// Shared types and constants for the DNS answer builder.
`default_nettype none
package dqab_pkg;
  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned REC_BYTES = 16;
  localparam int unsigned MAX_REPLY = 256;
  localparam logic [15:0] OPCODE_BITS = 16'h7800;
  localparam logic [7:0] QR_BIT = 8'h80;
  localparam logic [15:0] TYPE_A = 16'h0001;
  localparam logic [7:0] NAME_PTR_HI = 8'hC0;
  localparam logic [1:0] ST_REPLY = 2'd0;
  localparam logic [1:0] ST_OPCODE = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;
  localparam logic [1:0] CFG_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TTL = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;
endpackage
`default_nettype wire

### rtl/core/dqab_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module dqab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/dns_query_answer_builder_core.sv
// Top level of the DNS answer builder: byte capture, question walk, reply output.
//
// Request channel: one byte per word (request_byte, request_last), valid/ready.
// Bytes are written into the packet buffer one per cycle while collecting.
// After the last byte the block walks the header and the questions, reading
// the buffer one byte per read (each read has an address cycle, then a data cycle).
// Reply bytes come from the packet buffer, from the answer records or from zero
// fill; each byte is gathered in an address cycle and a data cycle, and each word
// is then held in the output register until taken.
// A drop gives one word with word_bytes 0 and a status code.
// No new request byte is taken until the last reply word has been taken; a
// stall on the reply side holds the output register and all state.
// Reset (rst, synchronous) restores the register defaults and empties the
// byte count; the buffer contents need no clearing.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
`default_nettype none
module dns_query_answer_builder_core
  import dqab_pkg::*;
#(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        request_valid,
  output logic             request_ready,
  input  wire logic [7:0]  request_byte,
  input  wire logic        request_last,
  output logic             reply_valid,
  input  wire logic        reply_ready,
  output logic [31:0]      reply_word,
  output logic [2:0]       word_bytes,
  output logic             reply_last,
  output logic [1:0]       reply_status
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LIM = (BUFFER_BYTES < MAX_REPLY) ? BUFFER_BYTES : MAX_REPLY;

  localparam logic [3:0] S_LOAD = 4'd0, S_HDR = 4'd1, S_CHK = 4'd2,
    S_NAME = 4'd3, S_TC = 4'd4, S_REC = 4'd5, S_OUT = 4'd6, S_OWAIT = 4'd7,
    S_DROP = 4'd8, S_HOLD = 4'd9, S_QNEXT = 4'd10;

  logic [31:0] answer_address, answer_ttl;
  logic [8:0]  reply_limit;
  logic [3:0]  state;
  logic [12:0] byte_count;
  logic        overflow_seen;
  logic [12:0] len;
  logic [8:0]  eff_limit;
  logic [15:0] flags, qd, qi;
  logic [12:0] pos, name_at;
  logic [2:0]  sub;
  logic [31:0] tc;
  logic        rd_pend;
  logic [AW-1:0] raddr;
  logic [AW-1:0] pkt_raddr;
  logic [7:0]  rdata;
  logic [12:0] total;
  logic [8:0]  obyte;
  logic [1:0]  ok;
  logic [31:0] wacc;
  // answer records: index -> qname pointer, type/class
  logic [7:0]  rec_cnt;
  logic        rec_we;
  logic [7:0]  rec_ram_addr;
  logic [44:0] rec_wdata, rec_rdata;

  // present the walk or output address in the address cycle itself
  assign pkt_raddr = (state == S_NAME || state == S_TC) ? AW'(pos) :
                     (state == S_OUT) ? AW'(obyte) : raddr;

  dqab_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_pkt (
    .clk(clk),
    .we(request_valid && request_ready && (byte_count < 13'(BUFFER_BYTES))),
    .waddr(byte_count[AW-1:0]), .wdata(request_byte),
    .raddr(pkt_raddr), .rdata(rdata));

  dqab_ram #(.WIDTH(45), .DEPTH(16)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_cnt[3:0]), .wdata(rec_wdata),
    .raddr(rec_ram_addr[3:0]), .rdata(rec_rdata));

  assign eff_limit = (reply_limit > 9'(LIM)) ? 9'(LIM) : reply_limit;
  assign request_ready = (state == S_LOAD);

  logic [12:0] rec_off;
  logic [3:0]  rec_byte;
  assign rec_off = 13'(obyte) - len;
  assign rec_byte = rec_off[3:0];
  assign rec_ram_addr = 8'(rec_off >> 4);

  function automatic logic [7:0] rec_sel(input logic [3:0] b, input logic [44:0] r,
                                         input logic [31:0] ttl, input logic [31:0] adr);
    logic [15:0] p;
    begin
      p = {NAME_PTR_HI, 8'h00} | {3'b000, r[44:32]};
      case (b)
        4'd0: rec_sel = p[15:8];
        4'd1: rec_sel = p[7:0];
        4'd2: rec_sel = r[31:24];
        4'd3: rec_sel = r[23:16];
        4'd4: rec_sel = r[15:8];
        4'd5: rec_sel = r[7:0];
        4'd6: rec_sel = ttl[31:24];
        4'd7: rec_sel = ttl[23:16];
        4'd8: rec_sel = ttl[15:8];
        4'd9: rec_sel = ttl[7:0];
        4'd10: rec_sel = 8'h00;
        4'd11: rec_sel = 8'h04;
        4'd12: rec_sel = adr[31:24];
        4'd13: rec_sel = adr[23:16];
        4'd14: rec_sel = adr[15:8];
        default: rec_sel = adr[7:0];
      endcase
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= 32'hC0A80401;
      answer_ttl <= 32'd60;
      reply_limit <= 9'd256;
      state <= S_LOAD;
      byte_count <= '0;
      overflow_seen <= 1'b0;
      reply_valid <= 1'b0;
      rec_we <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rec_we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDRESS: answer_address <= cfg_data;
          CFG_TTL: answer_ttl <= cfg_data;
          CFG_LIMIT: reply_limit <= cfg_data[8:0];
          default: ;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (request_valid) begin
            if (byte_count < 13'(BUFFER_BYTES)) byte_count <= byte_count + 13'd1;
            else overflow_seen <= 1'b1;
            if (request_last) begin
              len <= (byte_count < 13'(BUFFER_BYTES)) ? byte_count + 13'd1 : byte_count;
              state <= S_HDR;
              sub <= '0;
              raddr <= AW'(2);
              rd_pend <= 1'b0;
            end
          end
        end
        S_HDR: begin
          // fetch bytes 2..5, each with an address cycle, then a data cycle
          if (overflow_seen || len < 13'(HDR_BYTES) || len > 13'(eff_limit)) begin
            reply_status <= ST_LENGTH;
            state <= S_DROP;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            case (sub)
              3'd0: flags[15:8] <= rdata;
              3'd1: flags[7:0] <= rdata;
              3'd2: qd[15:8] <= rdata;
              default: qd[7:0] <= rdata;
            endcase
            raddr <= raddr + AW'(1);
            if (sub == 3'd3) state <= S_CHK;
            sub <= sub + 3'd1;
          end
        end
        S_CHK: begin
          total <= len + 13'({qd, 4'b0000} > 20'h1000 ? 13'h1FFF : 13'({qd, 4'b0000}));
          if ((flags & OPCODE_BITS) != 16'h0000) begin
            reply_status <= ST_OPCODE;
            state <= S_DROP;
          end else if ({4'b0000, qd, 4'b0000} + 24'(len) > 24'(eff_limit)) begin
            reply_status <= ST_LENGTH;
            state <= S_DROP;
          end else begin
            pos <= 13'(HDR_BYTES);
            qi <= '0;
            rec_cnt <= '0;
            state <= S_QNEXT;
          end
        end
        S_QNEXT: begin
          if (qi == qd) begin
            obyte <= '0;
            ok <= '0;
            wacc <= '0;
            rd_pend <= 1'b0;
            state <= S_OUT;
          end else begin
            name_at <= pos;
            rd_pend <= 1'b0;
            state <= S_NAME;
          end
        end
        S_NAME: begin
          if (pos >= len) begin
            reply_status <= ST_MALFORMED;
            state <= S_DROP;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (rdata == 8'h00) begin
              pos <= pos + 13'd1;
              sub <= '0;
              state <= S_TC;
              if (pos + 13'd5 > len) begin
                reply_status <= ST_MALFORMED;
                state <= S_DROP;
              end
            end else begin
              pos <= pos + 13'(rdata) + 13'd1;
            end
          end
        end
        S_TC: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            tc <= {tc[23:0], rdata};
            pos <= pos + 13'd1;
            sub <= sub + 3'd1;
            if (sub == 3'd3) state <= S_REC;
          end
        end
        S_REC: begin
          qi <= qi + 16'd1;
          if (tc[31:16] == TYPE_A) begin
            rec_we <= 1'b1;
            rec_wdata <= {name_at, tc};
          end
          state <= S_QNEXT;
        end
        S_OUT: begin
          // gather one reply byte per pass: address cycle, then data cycle
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            logic [7:0] b;
            rd_pend <= 1'b0;
            if (13'(obyte) < len) begin
              if (obyte == 9'd2) b = rdata | QR_BIT;
              else if (obyte == 9'd6) b = qd[15:8];
              else if (obyte == 9'd7) b = qd[7:0];
              else b = rdata;
            end else if ({5'b0, rec_ram_addr} < {5'b0, rec_cnt}) begin
              b = rec_sel(rec_byte, rec_rdata, answer_ttl, answer_address);
            end else begin
              b = 8'h00;
            end
            wacc <= wacc | ({b, 24'h0} >> {ok, 3'b000});
            obyte <= obyte + 9'd1;
            ok <= ok + 2'd1;
            if (ok == 2'd3 || 13'(obyte) + 13'd1 == total) begin
              reply_word <= wacc | ({b, 24'h0} >> {ok, 3'b000});
              word_bytes <= {1'b0, ok} + 3'd1;
              reply_last <= (13'(obyte) + 13'd1 == total);
              reply_status <= ST_REPLY;
              reply_valid <= 1'b1;
              state <= S_OWAIT;
            end
          end
        end
        S_OWAIT: begin
          if (reply_ready) begin
            reply_valid <= 1'b0;
            wacc <= '0;
            ok <= '0;
            if (reply_last) begin
              state <= S_LOAD;
              byte_count <= '0;
              overflow_seen <= 1'b0;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_DROP: begin
          reply_word <= '0;
          word_bytes <= '0;
          reply_last <= 1'b1;
          reply_valid <= 1'b1;
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (reply_ready) begin
            reply_valid <= 1'b0;
            state <= S_LOAD;
            byte_count <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (rec_we) rec_cnt <= rec_cnt + 8'd1;
    end
  end
endmodule
`default_nettype wire

### rtl/core/dqab_checker.sv
// Port-level checks for the DNS answer builder, bound to the top level.
`default_nettype none
module dqab_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        request_ready,
  input wire logic        reply_valid,
  input wire logic        reply_ready,
  input wire logic [2:0]  word_bytes,
  input wire logic        reply_last,
  input wire logic [1:0]  reply_status
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    reply_valid |-> !request_ready) else $error("request taken during reply");
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    reply_valid && word_bytes == 3'd0 |-> reply_last) else $error("drop not last");
  a_status: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_status != 2'd0 |-> word_bytes == 3'd0)
    else $error("status with data");
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_last |-> word_bytes == 3'd4) else $error("short mid word");
endmodule
bind dns_query_answer_builder_core dqab_checker u_chk (.*);
`default_nettype wire

### tb/dns_query_answer_builder_core_test.sv
// Testbench for the DNS answer builder: directed, configuration and random requests.
`timescale 1ns / 100ps
module dns_query_answer_builder_core_test;
  import dqab_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
    logic [1:0]  status;
  } reply_t;

  localparam int STORE_BYTES = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ADDRESS;
  logic [31:0] cfg_data = '0;
  logic        request_valid = 1'b0;
  logic        request_ready;
  logic [7:0]  request_byte = '0;
  logic        request_last = 1'b0;
  logic        reply_valid;
  logic        reply_ready = 1'b0;
  logic [31:0] reply_word;
  logic [2:0]  word_bytes;
  logic        reply_last;
  logic [1:0]  reply_status;

  dns_query_answer_builder_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .request_valid(request_valid), .request_ready(request_ready),
    .request_byte(request_byte), .request_last(request_last),
    .reply_valid(reply_valid), .reply_ready(reply_ready),
    .reply_word(reply_word), .word_bytes(word_bytes),
    .reply_last(reply_last), .reply_status(reply_status)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  req_store [STORE_BYTES];
  int          req_count = 0;
  bit          req_overflow = 0;
  logic [31:0] addr_reg = 32'hC0A80401;
  logic [31:0] ttl_reg = 32'd60;
  logic [8:0]  limit_reg = 9'd256;

  reply_t      expected_replies[$];
  logic [7:0]  pkt[$];
  int          errors = 0;
  bit          no_idle = 0;
  int          idle_cycles = 0;

  task automatic build_reply();
    int lim, len, qd, total, pos, ans, name_at, nwords, n;
    logic [1:0]  st;
    logic [15:0] flags, qtype, qclass;
    logic [7:0]  rb [STORE_BYTES];
    logic [31:0] w;
    reply_t r;
    len = req_count;
    lim = (limit_reg > STORE_BYTES) ? STORE_BYTES : limit_reg;
    st = ST_REPLY;
    total = 0;
    if (req_overflow || len < HDR_BYTES || len > lim) begin
      st = ST_LENGTH;
    end else begin
      flags = {req_store[2], req_store[3]};
      qd = {req_store[4], req_store[5]};
      total = len + qd * REC_BYTES;
      if ((flags & OPCODE_BITS) != 0) st = ST_OPCODE;
      else if (total > lim) st = ST_LENGTH;
    end
    if (st == ST_REPLY) begin
      for (int i = 0; i < STORE_BYTES; i++) rb[i] = (i < len) ? req_store[i] : 8'h00;
      rb[2] = req_store[2] | QR_BIT;
      rb[6] = req_store[4];
      rb[7] = req_store[5];
      pos = HDR_BYTES;
      ans = len;
      for (int q = 0; q < qd && st == ST_REPLY; q++) begin
        name_at = pos;
        // every nonzero name byte counts as a plain label length
        while (pos < len && req_store[pos] != 0) pos += req_store[pos] + 1;
        if (pos >= len) begin
          st = ST_MALFORMED;
        end else begin
          pos++;
          if (pos + 4 > len) begin
            st = ST_MALFORMED;
          end else begin
            qtype = {req_store[pos], req_store[pos+1]};
            qclass = {req_store[pos+2], req_store[pos+3]};
            pos += 4;
            if (qtype == TYPE_A) begin
              rb[ans] = NAME_PTR_HI;
              rb[ans+1] = name_at[7:0];
              {rb[ans+2], rb[ans+3]} = qtype;
              {rb[ans+4], rb[ans+5]} = qclass;
              {rb[ans+6], rb[ans+7], rb[ans+8], rb[ans+9]} = ttl_reg;
              rb[ans+10] = 8'h00;
              rb[ans+11] = 8'h04;
              {rb[ans+12], rb[ans+13], rb[ans+14], rb[ans+15]} = addr_reg;
              ans += REC_BYTES;
            end
          end
        end
      end
    end
    req_count = 0;
    req_overflow = 0;
    if (st != ST_REPLY) begin
      r = '{word: '0, nbytes: 3'd0, last: 1'b1, status: st};
      expected_replies.push_back(r);
    end else begin
      nwords = (total + 3) / 4;
      for (int k = 0; k < nwords; k++) begin
        n = total - 4 * k;
        if (n > 4) n = 4;
        w = '0;
        for (int b = 0; b < 4; b++) w = {w[23:0], (b < n) ? rb[4*k+b] : 8'h00};
        r = '{word: w, nbytes: n[2:0], last: (k == nwords - 1), status: ST_REPLY};
        expected_replies.push_back(r);
      end
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    if (req_count < STORE_BYTES) begin
      req_store[req_count] = b;
      req_count++;
    end else begin
      req_overflow = 1;
    end
    if (last) build_reply();
  endtask

  // Keep valid high across back-to-back words; drop it only for a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid <= 1'b1;
    request_byte <= b;
    request_last <= last;
    do @(posedge clk); while (!request_ready);
    absorb_byte(b, last);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_drained();
    request_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    // non-last bytes still in flight produce no result; let the walk finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ADDRESS: addr_reg = val;
      CFG_TTL:     ttl_reg = val;
      CFG_LIMIT:   limit_reg = val[8:0];
      default: ;
    endcase
  endtask

  // Assemble a request: header with qd_field, then nq questions.
  task automatic make_request(input int qd_field, input int nq, input logic [15:0] flags,
                              input bit a_only);
    int nlab, llen;
    pkt.delete();
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(flags[15:8]);
    pkt.push_back(flags[7:0]);
    pkt.push_back(qd_field[15:8]);
    pkt.push_back(qd_field[7:0]);
    repeat (6) pkt.push_back(8'($urandom_range(0, 255)));
    for (int q = 0; q < nq; q++) begin
      nlab = $urandom_range(1, 3);
      repeat (nlab) begin
        llen = $urandom_range(1, 5);
        pkt.push_back(8'(llen));
        repeat (llen) pkt.push_back(8'($urandom_range(0, 255)));
      end
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back((a_only || $urandom_range(0, 2) != 0) ? 8'h01 :
                    8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
      pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [15:0] query_flags();
    return 16'($urandom()) & ~OPCODE_BITS;
  endfunction

  task automatic test_directed();
    make_request(0, 0, 16'h0100, 1); send_packet();         // bare header
    make_request(0, 0, 16'h0000, 1); pkt.pop_back(); send_packet();  // short
    pkt.delete(); pkt.push_back(8'hFF); send_packet();       // single byte
    make_request(1, 1, 16'h0800, 1); send_packet();          // opcode low bit
    make_request(1, 1, 16'h7800, 1); send_packet();          // all opcode bits
    make_request(1, 1, 16'h87FF, 1); send_packet();          // all but opcode
    make_request(1, 1, 16'h0100, 1); send_packet();          // one A question
    make_request(3, 3, 16'h0100, 0); pkt[pkt.size()-4] = 8'h1C; send_packet();
    make_request(2, 2, 16'h0000, 1); send_packet();
    make_request(2, 1, 16'h0000, 1); send_packet();          // qd beyond questions
    make_request(1, 0, 16'h0000, 1); pkt.push_back(8'h05); pkt.push_back(8'h61);
    send_packet();                                           // label past end
    make_request(1, 1, 16'h0000, 1); pkt.pop_back(); send_packet();  // short type/class
    make_request(1, 0, 16'h0000, 1);                         // 0xC0 as label length
    pkt.push_back(8'hC0); pkt.push_back(8'h0C); repeat (4) pkt.push_back(8'h01);
    send_packet();
    make_request(15, 15, 16'h0000, 1); send_packet();        // reply over the limit
    make_request(0, 0, 16'h0000, 1);
    while (pkt.size() < 256) pkt.push_back(8'($urandom_range(0, 255)));
    send_packet();                                           // exactly full
    pkt.push_back(8'h00); pkt.push_back(8'hFF); send_packet();  // overflow
    make_request(16'hFFFF, 1, 16'h0000, 1); send_packet();
    make_request(1, 1, 16'h0000, 1); pkt[12] = 8'h00; pkt.push_back(8'h00);
    send_packet();                                           // root name
    wait_drained();
  endtask

  task automatic test_config();
    logic [8:0] limits[6] = '{9'd0, 9'd11, 9'd12, 9'd40, 9'd256, 9'd511};
    foreach (limits[i]) begin
      write_reg(CFG_LIMIT, {23'd0, limits[i]});
      write_reg(CFG_ADDRESS, (i % 2) ? 32'hFFFFFFFF : 32'h00000000);
      write_reg(CFG_TTL, (i % 2) ? 32'h00000000 : 32'hFFFFFFFF);
      make_request(0, 0, 16'h0000, 1); send_packet();
      make_request(1, 1, query_flags(), 1); send_packet();
      make_request(2, 2, query_flags(), 1); send_packet();
      wait_drained();
    end
    write_reg(CFG_ADDRESS, $urandom());
    write_reg(CFG_TTL, $urandom());
    write_reg(CFG_LIMIT, 32'd256);
  endtask

  task automatic test_random();
    int sent, nq, kind;
    sent = 0;
    while (sent < 260) begin
      no_idle = ($urandom_range(0, 4) == 0);
      nq = $urandom_range(0, 4);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        make_request(nq, nq, query_flags(), 0);
      end else if (kind == 7) begin
        make_request(nq, nq, 16'($urandom()), 0);
      end else if (kind == 8) begin
        make_request($urandom_range(0, 6), nq, query_flags(), 0);
        if (pkt.size() > 1) repeat ($urandom_range(0, 5)) pkt.pop_back();
      end else begin
        pkt.delete();
        repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(0, 255)));
      end
      send_packet();
      sent += pkt.size();
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        write_reg(CFG_ADDRESS, $urandom());
        write_reg(CFG_TTL, $urandom());
        write_reg(CFG_LIMIT, $urandom_range(12, 300));
      end
    end
    no_idle = 0;
    wait_drained();
  endtask

  // Reply side: check each word, then draw the stall before the next one.
  int stall_left = 0;
  always @(posedge clk) begin
    reply_t got, want;
    logic nxt;
    if (!rst) begin
      if (reply_valid && reply_ready) begin
        got = '{word: reply_word, nbytes: word_bytes, last: reply_last, status: reply_status};
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected word, actual %h/%0d/%b/%0d", $time,
                   got.word, got.nbytes, got.last, got.status);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.word !== want.word)
            $display("%0t: reply_word expected %h actual %h", $time, want.word, got.word);
          if (got.nbytes !== want.nbytes)
            $display("%0t: word_bytes expected %0d actual %0d", $time, want.nbytes, got.nbytes);
          if (got.last !== want.last)
            $display("%0t: reply_last expected %b actual %b", $time, want.last, got.last);
          if (got.status !== want.status)
            $display("%0t: reply_status expected %0d actual %0d", $time,
                     want.status, got.status);
          if (got !== want) errors++;
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 17);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      nxt = (stall_left == 0);
      reply_ready <= nxt;
    end
  end

  always @(posedge clk) begin
    if ((request_valid && request_ready) || (reply_valid && reply_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    test_random();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
